// ----- hdl/lspi_pkg.sv -----
// shared types and constants of the looped sample player
`default_nettype none
package lspi_pkg;

  // fixed point layout
  localparam int FRAC_BITS = 16;
  localparam int PHASE_W   = 34;
  localparam int IDX_W     = PHASE_W - FRAC_BITS;
  localparam int FM_W      = 20;
  localparam int GAIN_W    = 32;
  localparam int FM_SHIFT  = 20;
  localparam int PROD_W    = FM_W + GAIN_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [PHASE_W-1:0] PHASE_MAX = {1'b0, {(PHASE_W-1){1'b1}}};
  localparam logic signed [PHASE_W-1:0] PHASE_MIN = {1'b1, {(PHASE_W-1){1'b0}}};
  localparam logic signed [15:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SMP_MIN = 16'sh8000;

  // input item commands
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_FRAME   = 2'd1,
    CMD_RESTART = 2'd2
  } lspi_cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAYBACK_STEP = 3'd0,
    REG_FM_BASE_STEP  = 3'd1,
    REG_FM_GAIN       = 3'd2,
    REG_SAMPLE_LENGTH = 3'd3,
    REG_LOOP_ENABLE   = 3'd4,
    REG_LOOP_START    = 3'd5,
    REG_LOOP_END      = 3'd6
  } lspi_reg_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [13:0]        load_address;
    logic signed [15:0] load_value;
    logic signed [19:0] fm_offset;
    logic               fm_valid;
  } lspi_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               out_of_range;
  } lspi_out_t;

  typedef struct packed {
    logic [23:0] playback_step;
    logic [23:0] fm_base_step;
    logic [31:0] fm_gain;
    logic [14:0] sample_length;
    logic        loop_enable;
    logic [30:0] loop_start;
    logic [30:0] loop_end;
  } lspi_cfg_t;

  localparam lspi_cfg_t CFG_RESET = '{
    playback_step: 24'd65536,
    fm_base_step:  24'd65536,
    fm_gain:       32'd610080,
    sample_length: 15'd0,
    loop_enable:   1'b0,
    loop_start:    31'd0,
    loop_end:      31'd0
  };

  // operation handed to the memory and phase stage
  typedef struct packed {
    logic [1:0]                command;
    logic [13:0]               load_address;
    logic signed [15:0]        load_value;
    logic signed [PHASE_W-1:0] step;
  } lspi_op_t;

  // frame info traveling with the read data
  typedef struct packed {
    logic                 out_of_range;
    logic [FRAC_BITS-1:0] frac;
  } lspi_frame_t;

endpackage
`default_nettype wire

// ----- hdl/lspi_step.sv -----
// input register, fm product and phase step computation
`default_nettype none
module lspi_step import lspi_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lspi_in_t  in_item_i,
  input  wire lspi_cfg_t cfg_i,
  output logic           op_valid_o,
  input  wire logic      op_ready_i,
  output lspi_op_t       op_o
);

  logic                     v1_q;
  lspi_in_t                 in_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     rdy1, rdy2, adv1;
  logic                     v2_q;
  lspi_op_t                 op_q, op_d;
  logic signed [PHASE_W-1:0] fm_term;

  assign rdy2       = !v2_q || op_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign adv1       = v1_q && rdy2;
  assign in_ready_o = rdy1;

  // fm offset times gain, registered before any add
  assign prod_d = PROD_W'(in_item_i.fm_offset) * PROD_W'($signed({1'b0, cfg_i.fm_gain}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      in_q   <= in_item_i;
      prod_q <= prod_d;
    end
  end

  // step select: plain step or base plus scaled fm offset
  assign fm_term = PHASE_W'(prod_q >>> FM_SHIFT);

  always_comb begin
    op_d.command      = in_q.command;
    op_d.load_address = in_q.load_address;
    op_d.load_value   = in_q.load_value;
    if (in_q.fm_valid) begin
      op_d.step = $signed(PHASE_W'(cfg_i.fm_base_step)) + fm_term;
    end else begin
      op_d.step = $signed(PHASE_W'(cfg_i.playback_step));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = v2_q;
  assign op_o       = op_q;

  // stalled first stage keeps its product
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q && $stable(prod_q))
    else $error("fm product changed while stalled");

  // without fm the plain step is taken
  a_plain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 && !in_q.fm_valid |=> op_q.step == $signed(PHASE_W'($past(cfg_i.playback_step))))
    else $error("plain step not selected");

  // stalled operation holds
  a_op_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !op_ready_i |=> v2_q && $stable(op_q))
    else $error("operation changed while stalled");

endmodule
`default_nettype wire

// ----- hdl/lspi_core.sv -----
// sample memory and phase accumulator: loads, restarts and frame reads
`default_nettype none
module lspi_core import lspi_pkg::*; #(
  parameter int SAMPLE_DEPTH = 16384,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lspi_cfg_t                cfg_i,
  input  wire logic                     op_valid_i,
  output logic                          op_ready_o,
  input  wire lspi_op_t                 op_i,
  output logic                          rd_valid_o,
  input  wire logic                     rd_ready_i,
  output lspi_frame_t                   frame_o,
  output logic signed [SAMPLE_WIDTH-1:0] s1_o,
  output logic signed [SAMPLE_WIDTH-1:0] s2_o
);

  localparam int AW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int LenW = $clog2(SAMPLE_DEPTH + 1);

  logic signed [SAMPLE_WIDTH-1:0] sample_mem_q [SAMPLE_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] s1_q, s2_q;
  logic signed [PHASE_W-1:0]      phase_q, phase_d;
  logic                           rd_valid_q;
  lspi_frame_t                    frame_q;

  logic                  fire, is_load, is_frame, in_range, wr_ok, at_last;
  logic [LenW-1:0]       len;
  logic [IDX_W-1:0]      idx;
  logic [31:0]           idx_nx;
  logic [AW-1:0]         addr1, addr2, waddr;
  logic signed [PHASE_W:0]   sum;
  logic signed [PHASE_W-1:0] sat, loop_start_s, loop_end_s;

  assign op_ready_o = !rd_valid_q || rd_ready_i;
  assign fire       = op_valid_i && op_ready_o;
  assign is_load    = (op_i.command == CMD_LOAD);
  assign is_frame   = (op_i.command == CMD_FRAME);

  // effective length, capped at the memory depth
  always_comb begin
    if (32'(cfg_i.sample_length) > 32'(SAMPLE_DEPTH)) begin
      len = LenW'(SAMPLE_DEPTH);
    end else begin
      len = LenW'(cfg_i.sample_length);
    end
  end

  // read addresses at the phase, second one clamped to the last sample
  assign idx      = phase_q[PHASE_W-1:FRAC_BITS];
  assign in_range = !phase_q[PHASE_W-1] && (32'(idx) < 32'(len));
  assign idx_nx   = 32'(idx) + 32'd1;
  assign at_last  = idx_nx >= 32'(len);
  assign addr1    = AW'(idx);
  assign addr2    = at_last ? AW'(idx) : AW'(idx_nx);

  assign wr_ok = 32'(op_i.load_address) < 32'(SAMPLE_DEPTH);
  assign waddr = AW'(op_i.load_address);

  // sample memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (fire && is_load && wr_ok) begin
      sample_mem_q[waddr] <= SAMPLE_WIDTH'(op_i.load_value);
    end
    if (fire && is_frame && in_range) begin
      s1_q <= sample_mem_q[addr1];
      s2_q <= sample_mem_q[addr2];
    end
  end

  // phase advance with saturation and loop wrap
  assign loop_start_s = $signed(PHASE_W'(cfg_i.loop_start));
  assign loop_end_s   = $signed(PHASE_W'(cfg_i.loop_end));
  assign sum = {phase_q[PHASE_W-1], phase_q} + {op_i.step[PHASE_W-1], op_i.step};

  always_comb begin
    if (sum[PHASE_W] != sum[PHASE_W-1]) begin
      sat = sum[PHASE_W] ? PHASE_MIN : PHASE_MAX;
    end else begin
      sat = sum[PHASE_W-1:0];
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      unique case (op_i.command)
        CMD_RESTART: phase_d = '0;
        CMD_FRAME: begin
          if (in_range) begin
            phase_d = (cfg_i.loop_enable && (sat >= loop_end_s)) ? loop_start_s : sat;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // frame info beside the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (op_ready_o) begin
      rd_valid_q <= op_valid_i && is_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_frame) begin
      frame_q.out_of_range <= !in_range;
      frame_q.frac         <= phase_q[FRAC_BITS-1:0];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign frame_o    = frame_q;
  assign s1_o       = s1_q;
  assign s2_o       = s2_q;

  // restart clears the phase
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && op_i.command == CMD_RESTART |=> phase_q == '0)
    else $error("restart did not clear phase");

  // an out of range frame leaves the phase alone
  a_oor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_frame && !in_range |=> $stable(phase_q))
    else $error("phase moved on out of range frame");

  // with looping on the phase ends below loop end or at loop start
  a_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_frame && in_range && cfg_i.loop_enable
    |=> (phase_q < $past(loop_end_s)) || (phase_q == $past(loop_start_s)))
    else $error("loop wrap missed");

  // read data holds while the next stage is full
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q && !rd_ready_i |=> rd_valid_q && $stable(s1_q) && $stable(s2_q))
    else $error("read data lost while stalled");

endmodule
`default_nettype wire

// ----- hdl/lspi_interp.sv -----
// linear interpolation between the two samples and the output register
`default_nettype none
module lspi_interp import lspi_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_valid_i,
  output logic                               rd_ready_o,
  input  wire lspi_frame_t                   frame_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] s1_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] s2_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output lspi_out_t                          out_item_o
);

  localparam int PW = SAMPLE_WIDTH + FRAC_BITS + 2;
  localparam int YW = (SAMPLE_WIDTH + 2 > 17) ? SAMPLE_WIDTH + 2 : 17;

  logic                          v4_q, v5_q, rdy4, rdy5, adv3;
  logic signed [SAMPLE_WIDTH:0]  diff;
  logic signed [PW-1:0]          prod_d, prod_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_q;
  logic                          oor4_q;
  logic signed [YW-1:0]          y;
  lspi_out_t                     out_d, out_q;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign adv3       = rd_valid_i && rdy4;
  assign rd_ready_o = rdy4;

  // fraction times sample difference
  assign diff   = $signed({s2_i[SAMPLE_WIDTH-1], s2_i}) - $signed({s1_i[SAMPLE_WIDTH-1], s1_i});
  assign prod_d = PW'(diff) * PW'($signed({1'b0, frame_i.frac}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= rd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      prod_q <= prod_d;
      s1_q   <= s1_i;
      oor4_q <= frame_i.out_of_range;
    end
  end

  // add, saturate, force zero outside the sample
  assign y = YW'(s1_q) + YW'(prod_q >>> FRAC_BITS);

  always_comb begin
    out_d.out_of_range = oor4_q;
    if (oor4_q) begin
      out_d.sample_out = '0;
    end else if (y > YW'(SMP_MAX)) begin
      out_d.sample_out = SMP_MAX;
    end else if (y < YW'(SMP_MIN)) begin
      out_d.sample_out = SMP_MIN;
    end else begin
      out_d.sample_out = y[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && rdy5) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v5_q;
  assign out_item_o  = out_q;

  // out of range items leave as zero
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && rdy5 && oor4_q |=> out_q.out_of_range && out_q.sample_out == '0)
    else $error("out of range item not zero");

  // product stage holds while the output is full
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !rdy5 |=> v4_q && $stable(prod_q) && $stable(s1_q))
    else $error("product stage changed while stalled");

  // no item dropped when both stages are full and stalled
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && v5_q && !out_ready_i |=> v4_q && v5_q)
    else $error("item dropped under stall");

endmodule
`default_nettype wire

// ----- hdl/looped_sample_player_interp.sv -----
// top level of the looped sample player: config registers and pipeline
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o | in_item_i  (lspi_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_item_o (lspi_out_t)
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled; a frame result passes
// the input reg, step reg, memory read reg, product reg and output reg in turn.
// the phase add, saturation and loop compare are combinational in the memory stage.
// reset clears control state, phase and config; the sample memory is not cleared.
// each stage moves on when the next has room, so bubbles fill under output stalls.
`default_nettype none
module looped_sample_player_interp import lspi_pkg::*; #(
  parameter int SAMPLE_DEPTH = 16384,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lspi_in_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output lspi_out_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  lspi_cfg_t   cfg_q;
  logic        op_valid, op_ready, rd_valid, rd_ready;
  lspi_op_t    op;
  lspi_frame_t frame;
  logic signed [SAMPLE_WIDTH-1:0] s1, s2;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PLAYBACK_STEP: cfg_q.playback_step <= cfg_data_i[23:0];
        REG_FM_BASE_STEP:  cfg_q.fm_base_step  <= cfg_data_i[23:0];
        REG_FM_GAIN:       cfg_q.fm_gain       <= cfg_data_i[31:0];
        REG_SAMPLE_LENGTH: cfg_q.sample_length <= cfg_data_i[14:0];
        REG_LOOP_ENABLE:   cfg_q.loop_enable   <= cfg_data_i[0];
        REG_LOOP_START:    cfg_q.loop_start    <= cfg_data_i[30:0];
        REG_LOOP_END:      cfg_q.loop_end      <= cfg_data_i[30:0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  lspi_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  lspi_core #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (op_valid),
    .op_ready_o (op_ready),
    .op_i       (op),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .frame_o    (frame),
    .s1_o       (s1),
    .s2_o       (s2)
  );

  lspi_interp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (rd_valid),
    .rd_ready_o  (rd_ready),
    .frame_i     (frame),
    .s1_i        (s1),
    .s2_i        (s2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire
